/* src/uod_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uod_pkg
// Shared types, register indexes and constants of the ultrasonic obstacle
// detector.
// ----------------------------------------------------------------------------
package uod_pkg;

    // number of sensors by default
    localparam int NUM_SENSORS_DEFAULT = 3;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // register file
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] CFG_SCALE     = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_DIST  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_THRESHOLD = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_DEBOUNCE  = 2'd3;

    // register reset values
    localparam logic [15:0] SCALE_RESET     = 16'd1124;
    localparam logic [7:0]  MAX_DIST_RESET  = 8'd200;
    localparam logic [7:0]  THRESHOLD_RESET = 8'd20;
    localparam logic [15:0] DEBOUNCE_RESET  = 16'd500;

    // saturation limit of the millisecond counter
    localparam logic [15:0] SINCE_MAX = 16'hFFFF;

    // item function codes
    typedef enum logic [1:0] {
        FUNC_ECHO    = 2'd0,
        FUNC_TICK    = 2'd1,
        FUNC_MODE    = 2'd2,
        FUNC_RELEASE = 2'd3
    } func_t;

    // input beat
    typedef struct packed {
        logic [1:0]  func;
        logic [1:0]  sensor;
        logic [15:0] echo_us;
        logic        mode_active;
    } in_t;

    // result beat
    typedef struct packed {
        logic [7:0] distance_cm;
        logic       sensor_obstacle;
        logic       awaiting_confirm;
        logic       obstacle_any;
        logic       active;
    } out_t;

    // classified command passed from front to back
    typedef struct packed {
        func_t      func;
        logic [1:0] sensor;
        logic       sensor_ok;
        logic [7:0] echo_cm;
        logic       mode_active;
    } cmd_t;

    // configuration registers
    typedef struct packed {
        logic [15:0] scale;
        logic [7:0]  max_dist;
        logic [7:0]  threshold;
        logic [15:0] debounce;
    } cfg_t;

endpackage

/* src/uod_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uod_front
// Accepts input beats, decodes the function and converts the echo width
// into a saturated distance in centimetres.
// ----------------------------------------------------------------------------
module uod_front #(
    parameter int NUM_SENSORS = uod_pkg::NUM_SENSORS_DEFAULT
) (
    input  logic           s_valid,
    output logic           s_ready,
    input  uod_pkg::in_t   s_data,
    input  uod_pkg::cfg_t  cfg,
    output logic           q_valid,
    input  logic           q_ready,
    output uod_pkg::cmd_t  q_data
);

    logic [31:0] product;
    logic [7:0]  echo_cm;

    // handshake passes straight to the queue
    assign s_ready = q_ready;
    assign q_valid = s_valid;

    // echo width times Q0.16 scale, timeout gives the max distance
    assign product = 32'(s_data.echo_us) * 32'(cfg.scale);

    always_comb begin
        if (s_data.echo_us == 16'd0) begin
            echo_cm = cfg.max_dist;
        end else if (product[31:24] != 8'd0) begin
            echo_cm = 8'hFF;
        end else begin
            echo_cm = product[23:16];
        end
    end

    // classified command
    always_comb begin
        q_data.func        = uod_pkg::func_t'(s_data.func);
        q_data.sensor      = s_data.sensor;
        q_data.sensor_ok   = (int'(s_data.sensor) < NUM_SENSORS);
        q_data.echo_cm     = echo_cm;
        q_data.mode_active = s_data.mode_active;
    end

endmodule

/* src/uod_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uod_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module uod_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           wr_valid,
    output logic           wr_ready,
    input  uod_pkg::cmd_t  wr_data,
    output logic           rd_valid,
    input  logic           rd_ready,
    output uod_pkg::cmd_t  rd_data
);

    localparam int DEPTH = uod_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    uod_pkg::cmd_t    mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign wr_ready = (count_reg != CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd) begin
            count_next = count_reg + 1'b1;
        end else if (do_rd && !do_wr) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // fill count stays within depth
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    // a write without a read grows the count by one
    a_count_grow: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_wr && !do_rd) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not grow on write");

endmodule

/* src/uod_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uod_back
// Executes queued commands against the per-sensor state, the global flag
// and the millisecond counter, and registers one result per command.
// ----------------------------------------------------------------------------
module uod_back #(
    parameter int NUM_SENSORS = uod_pkg::NUM_SENSORS_DEFAULT
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_valid,
    output logic           q_ready,
    input  uod_pkg::cmd_t  q_data,
    input  uod_pkg::cfg_t  cfg,
    output logic           m_valid,
    input  logic           m_ready,
    output uod_pkg::out_t  m_data
);

    logic [7:0]             dist_reg  [NUM_SENSORS];
    logic [7:0]             dist_next [NUM_SENSORS];
    logic [7:0]             first_reg  [NUM_SENSORS];
    logic [7:0]             first_next [NUM_SENSORS];
    logic [NUM_SENSORS-1:0] flag_reg, flag_next;
    logic [NUM_SENSORS-1:0] pend_reg, pend_next;
    logic                   global_reg, global_next;
    logic                   active_reg, active_next;
    logic [15:0]            since_reg, since_next;
    logic                   m_valid_reg, m_valid_next;
    uod_pkg::out_t          m_data_reg, m_data_next;

    logic [NUM_SENSORS-1:0] hit;
    logic [7:0]             sel_first;
    logic [7:0]             sel_dist;
    logic                   sel_flag;
    logic                   sel_pend;
    logic [8:0]             sum;
    logic [7:0]             avg;
    logic                   avg_obst;
    logic                   pop;

    assign pop     = q_valid && (!m_valid_reg || m_ready);
    assign q_ready = !m_valid_reg || m_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // addressed sensor decode and held first reading
    always_comb begin
        sel_first = '0;
        for (int i = 0; i < NUM_SENSORS; i++) begin
            hit[i] = q_data.sensor_ok && (int'(q_data.sensor) == i);
            if (hit[i]) begin
                sel_first = first_reg[i];
            end
        end
    end

    // floor average of first and second reading
    assign sum      = {1'b0, sel_first} + {1'b0, q_data.echo_cm};
    assign avg      = sum[8:1];
    assign avg_obst = (avg < cfg.threshold);

    // state update for one command
    always_comb begin
        for (int i = 0; i < NUM_SENSORS; i++) begin
            dist_next[i]  = dist_reg[i];
            first_next[i] = first_reg[i];
        end
        flag_next   = flag_reg;
        pend_next   = pend_reg;
        global_next = global_reg;
        active_next = active_reg;
        since_next  = since_reg;

        if (pop) begin
            unique case (q_data.func)
                uod_pkg::FUNC_ECHO: begin
                    if (active_reg) begin
                        for (int i = 0; i < NUM_SENSORS; i++) begin
                            if (hit[i]) begin
                                if (!pend_reg[i]) begin
                                    if (q_data.echo_cm >= cfg.threshold) begin
                                        dist_next[i] = q_data.echo_cm;
                                        flag_next[i] = 1'b0;
                                    end else begin
                                        first_next[i] = q_data.echo_cm;
                                        pend_next[i]  = 1'b1;
                                    end
                                end else begin
                                    pend_next[i] = 1'b0;
                                    flag_next[i] = avg_obst;
                                    dist_next[i] = avg;
                                    if (avg_obst) begin
                                        global_next = 1'b1;
                                        since_next  = '0;
                                    end
                                end
                            end
                        end
                    end
                end
                uod_pkg::FUNC_TICK: begin
                    if (since_reg != uod_pkg::SINCE_MAX) begin
                        since_next = since_reg + 1'b1;
                    end
                end
                uod_pkg::FUNC_MODE: begin
                    active_next = q_data.mode_active;
                    if (!q_data.mode_active) begin
                        flag_next   = '0;
                        pend_next   = '0;
                        global_next = 1'b0;
                    end
                end
                uod_pkg::FUNC_RELEASE: begin
                    if (flag_reg == '0 && global_reg && since_reg > cfg.debounce) begin
                        global_next = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // per-sensor fields of the addressed sensor after the update
    always_comb begin
        sel_dist = '0;
        sel_flag = 1'b0;
        sel_pend = 1'b0;
        for (int i = 0; i < NUM_SENSORS; i++) begin
            if (hit[i]) begin
                sel_dist = dist_next[i];
                sel_flag = flag_next[i];
                sel_pend = pend_next[i];
            end
        end
    end

    // output register, refilled on each executed command
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (pop) begin
            m_valid_next                 = 1'b1;
            m_data_next.distance_cm      = sel_dist;
            m_data_next.sensor_obstacle  = sel_flag;
            m_data_next.awaiting_confirm = sel_pend;
            m_data_next.obstacle_any     = global_next;
            m_data_next.active           = active_next;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_SENSORS; i++) begin
                dist_reg[i] <= uod_pkg::MAX_DIST_RESET;
            end
            flag_reg    <= '0;
            pend_reg    <= '0;
            global_reg  <= 1'b0;
            active_reg  <= 1'b0;
            since_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            for (int i = 0; i < NUM_SENSORS; i++) begin
                dist_reg[i] <= dist_next[i];
            end
            flag_reg    <= flag_next;
            pend_reg    <= pend_next;
            global_reg  <= global_next;
            active_reg  <= active_next;
            since_reg   <= since_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        for (int i = 0; i < NUM_SENSORS; i++) begin
            first_reg[i] <= first_next[i];
        end
        m_data_reg <= m_data_next;
    end

    // a set sensor flag always comes with the global flag
    a_flag_global: assert property (@(posedge aclk) disable iff (!aresetn)
        (flag_reg != '0) |-> global_reg)
        else $error("sensor flag set without global flag");

    // inactive mode holds no pending reading and no sensor flag
    a_inactive_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !active_reg |-> (pend_reg == '0 && flag_reg == '0))
        else $error("state left over while inactive");

    // a completed reading that sets a flag restarts the counter
    a_since_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && q_data.func == uod_pkg::FUNC_ECHO && active_reg && (hit & pend_reg) != '0
         && avg_obst) |=> (since_reg == '0 && global_reg))
        else $error("counter not restarted on obstacle");

endmodule

/* src/ultrasonic_obstacle_detector.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ultrasonic_obstacle_detector
// Qualifies echo widths of several ultrasonic sensors into per-sensor and
// global obstacle flags with confirmation and release debounce.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data carry one item per beat: an echo reading, a
//   millisecond tick, a mode change or a release check. Every item gives
//   exactly one result beat on m_valid/m_ready/m_data, in order, holding the
//   addressed sensor's distance and flags and the global state after the item.
//   cfg_wr_en/cfg_addr/cfg_wdata write the scale, max distance, threshold and
//   debounce registers; write them only while no item is in work.
// Timing:
//   The front converts the echo (one 16x16 multiply) and pushes a command into
//   a two-entry queue; the back executes it and loads the output register.
//   The queue holds the command in a register and the output register then
//   holds the result. The back takes one item per cycle while m_ready is high
//   or the output register is empty; the state update is combinational.
// Reset and stall:
//   aresetn low for one clock restores register defaults, sets all stored
//   distances to 200 cm, clears flags, pending readings, counter and mode.
//   When m_ready is low the result stays in the output register, the queue
//   takes up to two more items, then s_ready drops until the result is taken.
// ----------------------------------------------------------------------------
module ultrasonic_obstacle_detector #(
    parameter int NUM_SENSORS = uod_pkg::NUM_SENSORS_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  uod_pkg::in_t                    s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output uod_pkg::out_t                   m_data,
    input  logic                            cfg_wr_en,
    input  logic [uod_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [uod_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    uod_pkg::cfg_t cfg_reg, cfg_next;
    uod_pkg::cmd_t front_cmd;
    uod_pkg::cmd_t queue_cmd;
    logic          front_valid, front_ready;
    logic          queue_valid, queue_ready;

    // register writes
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                uod_pkg::CFG_SCALE:     cfg_next.scale     = cfg_wdata;
                uod_pkg::CFG_MAX_DIST:  cfg_next.max_dist  = cfg_wdata[7:0];
                uod_pkg::CFG_THRESHOLD: cfg_next.threshold = cfg_wdata[7:0];
                uod_pkg::CFG_DEBOUNCE:  cfg_next.debounce  = cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.scale     <= uod_pkg::SCALE_RESET;
            cfg_reg.max_dist  <= uod_pkg::MAX_DIST_RESET;
            cfg_reg.threshold <= uod_pkg::THRESHOLD_RESET;
            cfg_reg.debounce  <= uod_pkg::DEBOUNCE_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // decode and echo conversion
    uod_front #(
        .NUM_SENSORS (NUM_SENSORS)
    ) u_front (
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .cfg     (cfg_reg),
        .q_valid (front_valid),
        .q_ready (front_ready),
        .q_data  (front_cmd)
    );

    // command queue
    uod_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .wr_data  (front_cmd),
        .rd_valid (queue_valid),
        .rd_ready (queue_ready),
        .rd_data  (queue_cmd)
    );

    // state update and result register
    uod_back #(
        .NUM_SENSORS (NUM_SENSORS)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (queue_valid),
        .q_ready (queue_ready),
        .q_data  (queue_cmd),
        .cfg     (cfg_reg),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

/* bench/tb_ultrasonic_obstacle_detector.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ultrasonic_obstacle_detector
// Drives echo readings, ticks, mode changes and release checks into the
// detector with random idle gaps on both channels. Each accepted beat is run
// through a local copy of the detector state to predict its report. Every
// report that comes back is checked field by field, in order, against it.
// ----------------------------------------------------------------------------
module tb_ultrasonic_obstacle_detector;

    localparam int NUM_SENSORS    = uod_pkg::NUM_SENSORS_DEFAULT;
    localparam int LONG_STALL     = 40;
    localparam int DRAIN_CYCLES   = 6;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_ITEMS    = 300;
    localparam int LAST_DEBOUNCE  = 30;

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           s_valid   = 1'b0;
    logic                           s_ready;
    uod_pkg::in_t                   s_data    = '0;
    logic                           m_valid;
    logic                           m_ready   = 1'b0;
    uod_pkg::out_t                  m_data;
    logic                           cfg_wr_en = 1'b0;
    logic [uod_pkg::CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [uod_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    // beats waiting to be offered, reports waiting to arrive
    uod_pkg::in_t  pending_items[$];
    uod_pkg::out_t expected_reports[$];
    int   mismatches = 0;

    // handshake bookkeeping between the edges
    bit   in_beat    = 1'b0;
    bit   out_beat   = 1'b0;
    int   in_gap     = 0;
    int   out_gap    = 0;
    bit   tx_burst   = 1'b0;
    bit   rx_burst   = 1'b0;
    int   stall_req  = 0;
    int   stall_ack  = 0;
    int   stall_left = 0;
    logic rx_hold    = 1'b0;
    int   stuck_cycles = 0;

    // local copy of registers and detector state
    logic [15:0] cfg_scale;
    logic [7:0]  cfg_max_dist;
    logic [7:0]  cfg_threshold;
    logic [15:0] cfg_debounce;
    logic [7:0]  dist_cm    [NUM_SENSORS];
    logic        near_flag  [NUM_SENSORS];
    logic        first_held [NUM_SENSORS];
    logic [7:0]  first_cm   [NUM_SENSORS];
    logic        any_near;
    logic        mode_on;
    logic [15:0] quiet_ms;

    ultrasonic_obstacle_detector #(
        .NUM_SENSORS(NUM_SENSORS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #6 aclk = ~aclk;

    // detector state after reset
    function automatic void clear_detector();
        cfg_scale     = uod_pkg::SCALE_RESET;
        cfg_max_dist  = uod_pkg::MAX_DIST_RESET;
        cfg_threshold = uod_pkg::THRESHOLD_RESET;
        cfg_debounce  = uod_pkg::DEBOUNCE_RESET;
        for (int i = 0; i < NUM_SENSORS; i++) begin
            dist_cm[i]    = uod_pkg::MAX_DIST_RESET;
            near_flag[i]  = 1'b0;
            first_held[i] = 1'b0;
            first_cm[i]   = 8'd0;
        end
        any_near = 1'b0;
        mode_on  = 1'b0;
        quiet_ms = 16'd0;
    endfunction

    // advance the local state by one beat and return the report it gives
    function automatic uod_pkg::out_t predict_report(uod_pkg::in_t it);
        uod_pkg::out_t rep;
        logic [31:0]   prod;
        logic [7:0]    cm;
        logic [8:0]    pair_sum;
        logic          flagged;
        int            s;
        s = int'(it.sensor);
        case (it.func)
            uod_pkg::FUNC_ECHO: begin
                if (mode_on && s < NUM_SENSORS) begin
                    // width to centimetres, timeout gives the max distance
                    prod = 32'(it.echo_us) * 32'(cfg_scale);
                    if (it.echo_us == 16'd0)
                        cm = cfg_max_dist;
                    else if (prod[31:16] > 16'd255)
                        cm = 8'd255;
                    else
                        cm = prod[23:16];
                    if (!first_held[s]) begin
                        if (cm >= cfg_threshold) begin
                            dist_cm[s]   = cm;
                            near_flag[s] = 1'b0;
                        end else begin
                            first_cm[s]   = cm;
                            first_held[s] = 1'b1;
                        end
                    end else begin
                        // confirmation: floor average of both readings
                        pair_sum      = {1'b0, first_cm[s]} + {1'b0, cm};
                        first_held[s] = 1'b0;
                        dist_cm[s]    = pair_sum[8:1];
                        near_flag[s]  = pair_sum[8:1] < cfg_threshold;
                        if (near_flag[s]) begin
                            any_near = 1'b1;
                            quiet_ms = 16'd0;
                        end
                    end
                end
            end
            uod_pkg::FUNC_TICK: begin
                if (quiet_ms != uod_pkg::SINCE_MAX)
                    quiet_ms = quiet_ms + 16'd1;
            end
            uod_pkg::FUNC_MODE: begin
                mode_on = it.mode_active;
                if (!it.mode_active) begin
                    for (int i = 0; i < NUM_SENSORS; i++) begin
                        near_flag[i]  = 1'b0;
                        first_held[i] = 1'b0;
                    end
                    any_near = 1'b0;
                end
            end
            default: begin
                flagged = 1'b0;
                for (int i = 0; i < NUM_SENSORS; i++)
                    flagged = flagged | near_flag[i];
                if (!flagged && any_near && quiet_ms > cfg_debounce)
                    any_near = 1'b0;
            end
        endcase
        rep = '0;
        if (s < NUM_SENSORS) begin
            rep.distance_cm      = dist_cm[s];
            rep.sensor_obstacle  = near_flag[s];
            rep.awaiting_confirm = first_held[s];
        end
        rep.obstacle_any = any_near;
        rep.active       = mode_on;
        return rep;
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // input side: predict on each accepted beat
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            expected_reports.push_back(predict_report(s_data));
            void'(pending_items.pop_front());
            in_beat = 1'b1;
        end
    end

    // input side: offer the next beat after its gap
    always @(negedge aclk) begin
        if (!(s_valid && !in_beat)) begin
            if (in_beat) begin
                in_gap  = tx_burst ? 0 : $urandom_range(0, 6);
                in_beat = 1'b0;
            end
            if (in_gap > 0) begin
                in_gap--;
                s_valid <= 1'b0;
            end else if (pending_items.size() != 0) begin
                s_valid <= 1'b1;
                s_data  <= pending_items[0];
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result side: compare each report with the oldest prediction
    always @(posedge aclk) begin
        uod_pkg::out_t want;
        if (aresetn && m_valid && m_ready) begin
            out_beat = 1'b1;
            if (expected_reports.size() == 0) begin
                $display("%0t: report with nothing expected, expected none, actual %h",
                         $time, m_data);
                mismatches++;
            end else begin
                want = expected_reports.pop_front();
                check_field("distance_cm", want.distance_cm, m_data.distance_cm);
                check_field("sensor_obstacle", 8'(want.sensor_obstacle),
                            8'(m_data.sensor_obstacle));
                check_field("awaiting_confirm", 8'(want.awaiting_confirm),
                            8'(m_data.awaiting_confirm));
                check_field("obstacle_any", 8'(want.obstacle_any), 8'(m_data.obstacle_any));
                check_field("active", 8'(want.active), 8'(m_data.active));
            end
        end
    end

    // result side: ready with random gaps, forced low during a long hold-off
    always @(negedge aclk) begin
        if (out_beat) begin
            out_gap  = rx_burst ? 0 : $urandom_range(0, 6);
            out_beat = 1'b0;
        end
        if (rx_hold) begin
            m_ready <= 1'b0;
        end else if (out_gap > 0) begin
            out_gap--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // long receiver hold-off, counted here
    always @(negedge aclk) begin
        if (stall_ack != stall_req) begin
            stall_ack  = stall_req;
            stall_left = LONG_STALL;
        end else if (stall_left > 0) begin
            stall_left--;
        end
        rx_hold <= (stall_left > 0);
    end

    // watchdog on cycles without any beat
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("FAIL");
            $finish;
        end
    end

    function automatic uod_pkg::in_t make_item(uod_pkg::func_t f, logic [1:0] s,
                                               logic [15:0] e, logic m);
        uod_pkg::in_t it;
        it.func        = f;
        it.sensor      = s;
        it.echo_us     = e;
        it.mode_active = m;
        return it;
    endfunction

    // mostly real sensors, now and then the unused index
    function automatic logic [1:0] pick_sensor();
        if ($urandom_range(0, 15) == 0)
            return 2'd3;
        return 2'($urandom_range(0, NUM_SENSORS - 1));
    endfunction

    // echo widths clustered around the threshold, plus timeouts and extremes
    function automatic logic [15:0] pick_echo();
        longint w;
        int     target;
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1, 2: return 16'($urandom);
            3: return 16'hFFFF;
            default: begin
                target = int'(cfg_threshold) + $urandom_range(0, 12) - 6;
                if (target < 0)
                    target = 0;
                if (cfg_scale == 16'd0)
                    return 16'($urandom);
                w = ((longint'(target) << 16) + $urandom_range(0, 65535)) / cfg_scale;
                if (w < 1)
                    w = 1;
                if (w > 65535)
                    w = 65535;
                return 16'(w);
            end
        endcase
    endfunction

    // wait until every beat is in and every report is out
    task automatic settle();
        do @(negedge aclk); while (pending_items.size() != 0 || expected_reports.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(logic [uod_pkg::CFG_ADDR_W-1:0] idx,
                             logic [uod_pkg::CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            uod_pkg::CFG_SCALE:     cfg_scale     = val;
            uod_pkg::CFG_MAX_DIST:  cfg_max_dist  = val[7:0];
            uod_pkg::CFG_THRESHOLD: cfg_threshold = val[7:0];
            uod_pkg::CFG_DEBOUNCE:  cfg_debounce  = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic configure(int scale, int max_dist, int threshold, int debounce);
        settle();
        write_reg(uod_pkg::CFG_SCALE, 16'(scale));
        write_reg(uod_pkg::CFG_MAX_DIST, 16'(max_dist));
        write_reg(uod_pkg::CFG_THRESHOLD, 16'(threshold));
        write_reg(uod_pkg::CFG_DEBOUNCE, 16'(debounce));
    endtask

    // random traffic made mostly of confirmation pairs, tick runs and releases
    task automatic random_traffic(int count);
        int         n;
        int         pick;
        int         runs;
        logic [1:0] s;
        n = 0;
        while (n < count) begin
            pick = $urandom_range(0, 99);
            s    = pick_sensor();
            if (pick < 45) begin
                pending_items.push_back(make_item(uod_pkg::FUNC_ECHO, s, pick_echo(),
                                                  1'($urandom)));
                if ($urandom_range(0, 3) == 0) begin
                    pending_items.push_back(make_item(uod_pkg::FUNC_ECHO, pick_sensor(),
                                                      pick_echo(), 1'($urandom)));
                    n++;
                end
                pending_items.push_back(make_item(uod_pkg::FUNC_ECHO, s, pick_echo(),
                                                  1'($urandom)));
                n += 2;
            end else if (pick < 58) begin
                pending_items.push_back(make_item(uod_pkg::FUNC_ECHO, s, pick_echo(),
                                                  1'($urandom)));
                n++;
            end else if (pick < 76) begin
                runs = $urandom_range(1, 10);
                repeat (runs)
                    pending_items.push_back(make_item(uod_pkg::FUNC_TICK, pick_sensor(),
                                                      16'($urandom), 1'($urandom)));
                n += runs;
            end else if (pick < 92) begin
                pending_items.push_back(make_item(uod_pkg::FUNC_RELEASE, s, 16'($urandom),
                                                  1'($urandom)));
                n++;
            end else if ($urandom_range(0, 9) < 7) begin
                pending_items.push_back(make_item(uod_pkg::FUNC_MODE, s, 16'($urandom), 1'b1));
                n++;
            end else begin
                // short inactive spell, then back to active
                pending_items.push_back(make_item(uod_pkg::FUNC_MODE, s, 16'($urandom), 1'b0));
                runs = $urandom_range(0, 3);
                repeat (runs)
                    pending_items.push_back(make_item(uod_pkg::FUNC_ECHO, pick_sensor(),
                                                      pick_echo(), 1'($urandom)));
                pending_items.push_back(make_item(uod_pkg::FUNC_MODE, pick_sensor(),
                                                  16'($urandom), 1'b1));
                n += runs + 2;
            end
        end
    endtask

    initial begin
        clear_detector();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed beats at the reset register values
        @(posedge aclk);
        pending_items.push_back(make_item(uod_pkg::FUNC_ECHO, 2'd0, 16'd100, 1'b0));
        pending_items.push_back(make_item(uod_pkg::FUNC_RELEASE, 2'd3, 16'd0, 1'b0));
        pending_items.push_back(make_item(uod_pkg::FUNC_MODE, 2'd0, 16'd0, 1'b1));
        pending_items.push_back(make_item(uod_pkg::FUNC_ECHO, 2'd0, 16'd0, 1'b0));
        pending_items.push_back(make_item(uod_pkg::FUNC_ECHO, 2'd0, 16'hFFFF, 1'b0));
        pending_items.push_back(make_item(uod_pkg::FUNC_ECHO, 2'd1, 16'd1, 1'b0));
        pending_items.push_back(make_item(uod_pkg::FUNC_ECHO, 2'd1, 16'hFFFF, 1'b0));
        pending_items.push_back(make_item(uod_pkg::FUNC_ECHO, 2'd2, 16'd500, 1'b0));
        pending_items.push_back(make_item(uod_pkg::FUNC_ECHO, 2'd2, 16'd700, 1'b0));
        pending_items.push_back(make_item(uod_pkg::FUNC_TICK, 2'd2, 16'd0, 1'b0));
        pending_items.push_back(make_item(uod_pkg::FUNC_RELEASE, 2'd2, 16'd0, 1'b0));
        pending_items.push_back(make_item(uod_pkg::FUNC_ECHO, 2'd2, 16'd1167, 1'b0));
        pending_items.push_back(make_item(uod_pkg::FUNC_ECHO, 2'd0, 16'd1166, 1'b0));
        pending_items.push_back(make_item(uod_pkg::FUNC_MODE, 2'd0, 16'd0, 1'b0));
        pending_items.push_back(make_item(uod_pkg::FUNC_ECHO, 2'd0, 16'd5, 1'b0));
        pending_items.push_back(make_item(uod_pkg::FUNC_MODE, 2'd1, 16'd0, 1'b1));
        pending_items.push_back(make_item(uod_pkg::FUNC_ECHO, 2'd1, 16'd100, 1'b0));
        pending_items.push_back(make_item(uod_pkg::FUNC_ECHO, 2'd1, 16'd0, 1'b0));
        pending_items.push_back(make_item(uod_pkg::FUNC_ECHO, 2'd1, 16'd3, 1'b0));
        pending_items.push_back(make_item(uod_pkg::FUNC_ECHO, 2'd1, 16'd3, 1'b0));
        pending_items.push_back(make_item(uod_pkg::FUNC_ECHO, 2'd3, 16'd3, 1'b1));
        pending_items.push_back(make_item(uod_pkg::FUNC_ECHO, 2'd1, 16'd2000, 1'b1));
        pending_items.push_back(make_item(uod_pkg::FUNC_RELEASE, 2'd1, 16'hFFFF, 1'b1));
        pending_items.push_back(make_item(uod_pkg::FUNC_MODE, 2'd2, 16'hFFFF, 1'b1));

        // random phases over several register settings
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: configure(1124, 200, 20, 12);
                1: configure(65535, 255, 255, 0);
                2: configure(0, 0, 0, 3);
                3: configure(1, $urandom_range(0, 255), 1, 65534);
                default: configure($urandom_range(0, 65535), $urandom_range(0, 255),
                                   $urandom_range(0, 255), $urandom_range(0, 30));
            endcase
            @(posedge aclk);
            tx_burst = (ph == 0 || ph == 4);
            rx_burst = (ph == 2 || ph == 4);
            pending_items.push_back(make_item(uod_pkg::FUNC_MODE, pick_sensor(),
                                              16'($urandom), 1'b1));
            random_traffic(PHASE_ITEMS);
            // hold the result side while the sender keeps going
            if (ph == 0)
                stall_req++;
        end

        // release exactly at the debounce time and just past it
        configure(1124, 200, 20, LAST_DEBOUNCE);
        @(posedge aclk);
        tx_burst = 1'b1;
        rx_burst = 1'b1;
        pending_items.push_back(make_item(uod_pkg::FUNC_MODE, 2'd0, 16'd0, 1'b0));
        pending_items.push_back(make_item(uod_pkg::FUNC_MODE, 2'd0, 16'd0, 1'b1));
        pending_items.push_back(make_item(uod_pkg::FUNC_ECHO, 2'd0, 16'd1, 1'b0));
        pending_items.push_back(make_item(uod_pkg::FUNC_ECHO, 2'd0, 16'd1, 1'b0));
        pending_items.push_back(make_item(uod_pkg::FUNC_ECHO, 2'd0, 16'd0, 1'b0));
        repeat (LAST_DEBOUNCE)
            pending_items.push_back(make_item(uod_pkg::FUNC_TICK, 2'd0, 16'($urandom),
                                              1'($urandom)));
        pending_items.push_back(make_item(uod_pkg::FUNC_RELEASE, 2'd0, 16'd0, 1'b0));
        pending_items.push_back(make_item(uod_pkg::FUNC_TICK, 2'd1, 16'd0, 1'b0));
        pending_items.push_back(make_item(uod_pkg::FUNC_RELEASE, 2'd0, 16'd0, 1'b0));
        repeat (3)
            pending_items.push_back(make_item(uod_pkg::FUNC_TICK, 2'd2, 16'd0, 1'b0));
        pending_items.push_back(make_item(uod_pkg::FUNC_RELEASE, 2'd2, 16'd0, 1'b1));

        settle();
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
